@@ rtl/hmf_pkg.sv @@
// hmf_pkg: shared types, codes and constants of the HTTP message framer.
// Depends on nothing.
`timescale 1ns / 1ps
package hmf_pkg;

    localparam int WHITESPACE_HOLD_DEF = 15;
    localparam int LENGTH_WIDTH_DEF    = 32;

    localparam int LEN_NAME_SIZE = 14;
    localparam int ENC_NAME_SIZE = 17;
    localparam logic [8*LEN_NAME_SIZE-1:0] LEN_NAME = "Content-Length";
    localparam logic [8*ENC_NAME_SIZE-1:0] ENC_NAME = "Transfer-Encoding";
    localparam logic [4:0] PROGRESS_DEAD = 5'd31;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] CLS_DROP    = 3'd0;
    localparam logic [2:0] CLS_METHOD  = 3'd1;
    localparam logic [2:0] CLS_VALUE   = 3'd5;
    localparam logic [2:0] CLS_NAME    = 3'd4;
    localparam logic [2:0] CLS_BODY    = 3'd6;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_BARE_CR = 3'd1;
    localparam logic [2:0] ERR_HEADER  = 3'd2;
    localparam logic [2:0] ERR_TE      = 3'd3;
    localparam logic [2:0] ERR_LENGTH  = 3'd4;

    typedef enum logic [3:0] {
        PH_SKIP  = 4'b0001,
        PH_START = 4'b0010,
        PH_HDR   = 4'b0100,
        PH_BODY  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_class;
        logic       field_end;
        logic       message_end;
        logic [2:0] error_code;
    } cmd_t;

    function automatic logic [4:0] name_advance(input logic [4:0] prog,
                                                input logic [7:0] b,
                                                input logic       enc);
        int         i;
        logic [7:0] ch;
        i  = int'(prog);
        ch = 8'h00;
        if (enc)
        begin
            if (i < ENC_NAME_SIZE)
                ch = ENC_NAME[8*(ENC_NAME_SIZE-1-i) +: 8];
            return (i < ENC_NAME_SIZE && ch == b) ? prog + 5'd1 : PROGRESS_DEAD;
        end
        if (i < LEN_NAME_SIZE)
            ch = LEN_NAME[8*(LEN_NAME_SIZE-1-i) +: 8];
        return (i < LEN_NAME_SIZE && ch == b) ? prog + 5'd1 : PROGRESS_DEAD;
    endfunction

endpackage

@@ rtl/hmf_if.sv @@
// hmf_if: valid/ready stream interfaces for input bytes and tagged result words.
// Depends on nothing.
`timescale 1ns / 1ps
interface hmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] byte_class;
    logic       field_end;
    logic       message_end;
    logic [2:0] error_code;
    logic       last_of_run;
    modport source (output valid, output out_byte, output byte_class, output field_end,
                    output message_end, output error_code, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_class, input field_end,
                    input message_end, input error_code, input last_of_run,
                    output ready);
endinterface

@@ rtl/hmf_front.sv @@
// hmf_front: accepts bytes, runs the message parser state and issues commands.
// Depends on hmf_pkg.
`timescale 1ns / 1ps
module hmf_front #(
    parameter int WHITESPACE_HOLD = hmf_pkg::WHITESPACE_HOLD_DEF,
    parameter int LENGTH_WIDTH    = hmf_pkg::LENGTH_WIDTH_DEF,
    parameter int HW              = $clog2(WHITESPACE_HOLD + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [7:0]                 in_byte,
    output logic                       in_ready,
    input  logic                       q_full,
    output logic                       push,
    output hmf_pkg::cmd_t              push_cmd,
    output logic [HW-1:0]              push_count,
    output logic [WHITESPACE_HOLD-1:0] push_bits
);
    localparam logic [HW-1:0] HOLD_MAX = HW'(WHITESPACE_HOLD);

    hmf_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  tok_reg, tok_next;
    logic        cr_reg, cr_next;
    logic        empty_reg, empty_next;
    logic        colon_reg, colon_next;
    logic        vstart_reg, vstart_next;
    logic [4:0]  lprog_reg, lprog_next;
    logic [4:0]  eprog_reg, eprog_next;
    logic        haslen_reg, haslen_next;
    logic        hasenc_reg, hasenc_next;
    logic [LENGTH_WIDTH-1:0] acc_reg, acc_next;
    logic [LENGTH_WIDTH-1:0] rem_reg, rem_next;
    logic [WHITESPACE_HOLD-1:0] held_reg, held_next;
    logic [HW-1:0] hc_reg, hc_next;
    logic [2:0]  err_reg, err_next;

    logic                    take;
    logic                    emit;
    logic [7:0]              b;
    logic [2:0]              cls;
    logic                    fe, me;
    logic [HW-1:0]           rel;
    logic [LENGTH_WIDTH+3:0] prod;
    logic                    ws;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;
    assign b        = in_byte;
    assign ws       = (b == hmf_pkg::CH_SP) || (b == hmf_pkg::CH_TAB);
    assign prod     = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + (LENGTH_WIDTH+4)'(b - hmf_pkg::CH_ZERO);

    always_comb
    begin
        phase_next  = phase_reg;
        tok_next    = tok_reg;
        cr_next     = cr_reg;
        empty_next  = empty_reg;
        colon_next  = colon_reg;
        vstart_next = vstart_reg;
        lprog_next  = lprog_reg;
        eprog_next  = eprog_reg;
        haslen_next = haslen_reg;
        hasenc_next = hasenc_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        held_next   = held_reg;
        hc_next     = hc_reg;
        err_next    = err_reg;
        emit        = 1'b1;
        cls         = hmf_pkg::CLS_DROP;
        fe          = 1'b0;
        me          = 1'b0;
        rel         = '0;
        if (err_reg != hmf_pkg::ERR_NONE)
        begin
            emit = 1'b1;
        end
        else if (phase_reg == hmf_pkg::PH_BODY)
        begin
            cls = hmf_pkg::CLS_BODY;
            if (rem_reg <= LENGTH_WIDTH'(1))
            begin
                me          = 1'b1;
                phase_next  = hmf_pkg::PH_SKIP;
                tok_next    = '0;
                haslen_next = 1'b0;
                hasenc_next = 1'b0;
                rem_next    = '0;
            end
            else
                rem_next = rem_reg - LENGTH_WIDTH'(1);
        end
        else if (cr_reg)
        begin
            cr_next = 1'b0;
            if (b != hmf_pkg::CH_LF)
                err_next = hmf_pkg::ERR_BARE_CR;
            else if (phase_reg == hmf_pkg::PH_START)
            begin
                fe         = 1'b1;
                phase_next = hmf_pkg::PH_HDR;
                empty_next = 1'b1; colon_next = 1'b0; vstart_next = 1'b0;
                lprog_next = '0; eprog_next = '0; acc_next = '0; hc_next = '0;
            end
            else if (phase_reg == hmf_pkg::PH_HDR)
            begin
                if (empty_reg)
                begin
                    if (hasenc_reg)
                        err_next = hmf_pkg::ERR_TE;
                    else if (!haslen_reg || rem_reg == '0)
                    begin
                        me          = 1'b1;
                        phase_next  = hmf_pkg::PH_SKIP;
                        tok_next    = '0;
                        haslen_next = 1'b0;
                        hasenc_next = 1'b0;
                        rem_next    = '0;
                        empty_next = 1'b1; colon_next = 1'b0; vstart_next = 1'b0;
                        lprog_next = '0; eprog_next = '0; acc_next = '0; hc_next = '0;
                    end
                    else
                        phase_next = hmf_pkg::PH_BODY;
                end
                else if (!colon_reg || !vstart_reg)
                    err_next = hmf_pkg::ERR_HEADER;
                else
                begin
                    fe = 1'b1;
                    if (eprog_reg == 5'(hmf_pkg::ENC_NAME_SIZE))
                        hasenc_next = 1'b1;
                    if (lprog_reg == 5'(hmf_pkg::LEN_NAME_SIZE))
                    begin
                        haslen_next = 1'b1;
                        rem_next    = acc_reg;
                    end
                    empty_next = 1'b1; colon_next = 1'b0; vstart_next = 1'b0;
                    lprog_next = '0; eprog_next = '0; acc_next = '0; hc_next = '0;
                end
            end
        end
        else if (b == hmf_pkg::CH_CR)
            cr_next = 1'b1;
        else if (phase_reg == hmf_pkg::PH_SKIP || phase_reg == hmf_pkg::PH_START)
        begin
            phase_next = hmf_pkg::PH_START;
            if (b == hmf_pkg::CH_SP && tok_reg < 2'd2)
            begin
                tok_next = tok_reg + 2'd1;
                fe       = 1'b1;
            end
            else
                cls = hmf_pkg::CLS_METHOD + {1'b0, tok_reg};
        end
        else
        begin
            empty_next = 1'b0;
            if (!colon_reg)
            begin
                if (b == hmf_pkg::CH_COLON)
                    colon_next = 1'b1;
                else
                begin
                    lprog_next = hmf_pkg::name_advance(lprog_reg, b, 1'b0);
                    eprog_next = hmf_pkg::name_advance(eprog_reg, b, 1'b1);
                    cls        = hmf_pkg::CLS_NAME;
                end
            end
            else if (ws)
            begin
                if (vstart_reg && hc_reg < HOLD_MAX)
                begin
                    emit = 1'b0;
                    held_next[hc_reg] = (b == hmf_pkg::CH_TAB);
                    hc_next = hc_reg + HW'(1);
                end
                else if (vstart_reg)
                    err_next = hmf_pkg::ERR_HEADER;
            end
            else if (lprog_reg == 5'(hmf_pkg::LEN_NAME_SIZE) &&
                     (b < hmf_pkg::CH_ZERO || b > hmf_pkg::CH_NINE || hc_reg != '0 ||
                      prod[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0))
                err_next = hmf_pkg::ERR_LENGTH;
            else
            begin
                if (lprog_reg == 5'(hmf_pkg::LEN_NAME_SIZE))
                    acc_next = prod[LENGTH_WIDTH-1:0];
                vstart_next = 1'b1;
                rel         = hc_reg;
                hc_next     = '0;
                cls         = hmf_pkg::CLS_VALUE;
            end
        end
    end

    assign push                 = take && emit;
    assign push_cmd.out_byte    = b;
    assign push_cmd.byte_class  = (err_next != hmf_pkg::ERR_NONE) ? hmf_pkg::CLS_DROP : cls;
    assign push_cmd.field_end   = (err_next != hmf_pkg::ERR_NONE) ? 1'b0 : fe;
    assign push_cmd.message_end = (err_next != hmf_pkg::ERR_NONE) ? 1'b0 : me;
    assign push_cmd.error_code  = err_next;
    assign push_count           = rel;
    assign push_bits            = held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hmf_pkg::PH_SKIP;
            tok_reg    <= '0;
            cr_reg     <= 1'b0;
            empty_reg  <= 1'b1;
            colon_reg  <= 1'b0;
            vstart_reg <= 1'b0;
            lprog_reg  <= '0;
            eprog_reg  <= '0;
            haslen_reg <= 1'b0;
            hasenc_reg <= 1'b0;
            acc_reg    <= '0;
            rem_reg    <= '0;
            hc_reg     <= '0;
            err_reg    <= hmf_pkg::ERR_NONE;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            tok_reg    <= tok_next;
            cr_reg     <= cr_next;
            empty_reg  <= empty_next;
            colon_reg  <= colon_next;
            vstart_reg <= vstart_next;
            lprog_reg  <= lprog_next;
            eprog_reg  <= eprog_next;
            haslen_reg <= haslen_next;
            hasenc_reg <= hasenc_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            hc_reg     <= hc_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            held_reg <= held_next;
    end
endmodule

@@ rtl/hmf_back.sv @@
// hmf_back: two-entry command queue and result emitter that releases held whitespace.
// Depends on hmf_pkg.
`timescale 1ns / 1ps
module hmf_back #(
    parameter int WHITESPACE_HOLD = hmf_pkg::WHITESPACE_HOLD_DEF,
    parameter int HW              = $clog2(WHITESPACE_HOLD + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  hmf_pkg::cmd_t              push_cmd,
    input  logic [HW-1:0]              push_count,
    input  logic [WHITESPACE_HOLD-1:0] push_bits,
    output logic                       q_full,
    output logic                       out_valid,
    input  logic                       out_ready,
    output hmf_pkg::cmd_t              out_cmd,
    output logic                       out_last
);
    hmf_pkg::cmd_t              cmd_mem [2];
    logic [HW-1:0]              cnt_mem [2];
    logic [WHITESPACE_HOLD-1:0] bits_mem [2];

    logic          wr_reg, rd_reg;
    logic [1:0]    fill_reg;
    logic [HW-1:0] idx_reg;
    logic          releasing;
    logic          pop;
    logic          tab_bit;

    assign q_full    = (fill_reg == 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign releasing = idx_reg < cnt_mem[rd_reg];
    assign pop       = out_valid && out_ready && !releasing;
    assign tab_bit   = bits_mem[rd_reg][idx_reg];

    always_comb
    begin
        out_cmd  = cmd_mem[rd_reg];
        out_last = 1'b1;
        if (releasing)
        begin
            out_cmd.out_byte    = tab_bit ? hmf_pkg::CH_TAB : hmf_pkg::CH_SP;
            out_cmd.byte_class  = hmf_pkg::CLS_VALUE;
            out_cmd.field_end   = 1'b0;
            out_cmd.message_end = 1'b0;
            out_last            = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_reg]  <= push_cmd;
            cnt_mem[wr_reg]  <= push_count;
            bits_mem[wr_reg] <= push_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
            idx_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
            begin
                rd_reg  <= !rd_reg;
                idx_reg <= '0;
            end
            else if (out_valid && out_ready)
                idx_reg <= idx_reg + HW'(1);
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ rtl/http_message_framer_core.sv @@
// A word's command is registered in the queue before the word shows on framed.
// Throughput: one byte per cycle while the queue is not full; a value byte that
// releases held spaces or tabs gives a word for each of them ahead of its own word.
// Held whitespace bytes give no word. Input stalls only when the queue is full.
// Reset (rst_n low, asynchronous) clears parser state, errors and the queue.
`timescale 1ns / 1ps
module http_message_framer_core #(
    parameter int WHITESPACE_HOLD = hmf_pkg::WHITESPACE_HOLD_DEF,
    parameter int LENGTH_WIDTH    = hmf_pkg::LENGTH_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    hmf_in_if.sink     raw,
    hmf_out_if.source  framed
);
    localparam int HW = $clog2(WHITESPACE_HOLD + 1);

    logic                       q_full;
    logic                       push;
    hmf_pkg::cmd_t              push_cmd;
    logic [HW-1:0]              push_count;
    logic [WHITESPACE_HOLD-1:0] push_bits;
    hmf_pkg::cmd_t              out_cmd;
    logic                       out_last;

    hmf_front #(.WHITESPACE_HOLD(WHITESPACE_HOLD), .LENGTH_WIDTH(LENGTH_WIDTH), .HW(HW))
    u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(raw.valid), .in_byte(raw.data_byte), .in_ready(raw.ready),
        .q_full(q_full), .push(push), .push_cmd(push_cmd),
        .push_count(push_count), .push_bits(push_bits)
    );

    hmf_back #(.WHITESPACE_HOLD(WHITESPACE_HOLD), .HW(HW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_cmd(push_cmd), .push_count(push_count), .push_bits(push_bits),
        .q_full(q_full), .out_valid(framed.valid), .out_ready(framed.ready),
        .out_cmd(out_cmd), .out_last(out_last)
    );

    assign framed.out_byte    = out_cmd.out_byte;
    assign framed.byte_class  = out_cmd.byte_class;
    assign framed.field_end   = out_cmd.field_end;
    assign framed.message_end = out_cmd.message_end;
    assign framed.error_code  = out_cmd.error_code;
    assign framed.last_of_run = out_last;
endmodule

@@ rtl/hmf_checker.sv @@
// hmf_checker: port-level assertions on the framer's result stream.
// Depends on hmf_pkg; bound to http_message_framer_core.
`timescale 1ns / 1ps
module hmf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] out_byte,
    input logic [2:0] byte_class,
    input logic       field_end,
    input logic       message_end,
    input logic [2:0] error_code
);
    logic [2:0] seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= hmf_pkg::ERR_NONE;
        else if (valid && ready && seen_reg == hmf_pkg::ERR_NONE)
            seen_reg <= error_code;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(out_byte))
        else $error("result word changed while stalled");

    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        valid && seen_reg != hmf_pkg::ERR_NONE |-> error_code == seen_reg)
        else $error("error code did not stick");

    a_err_drop: assert property (@(posedge clk) disable iff (!rst_n)
        valid && error_code != hmf_pkg::ERR_NONE |->
        byte_class == hmf_pkg::CLS_DROP && !field_end && !message_end)
        else $error("tagged word under error");
endmodule

bind http_message_framer_core hmf_checker u_hmf_checker (
    .clk(clk), .rst_n(rst_n),
    .valid(framed.valid), .ready(framed.ready), .out_byte(framed.out_byte),
    .byte_class(framed.byte_class), .field_end(framed.field_end),
    .message_end(framed.message_end), .error_code(framed.error_code)
);

@@ dv/http_message_framer_core_tb.sv @@
// http_message_framer_core_tb: self-checking bench for the HTTP message framer.
// Drives byte streams, predicts each tagged result word and compares in order.
// Depends on hmf_pkg, hmf_if and http_message_framer_core.
`timescale 1ns / 1ps
module http_message_framer_core_tb;

    localparam int HOLD       = hmf_pkg::WHITESPACE_HOLD_DEF;
    localparam int LEN_BITS   = hmf_pkg::LENGTH_WIDTH_DEF;
    localparam int RAND_ITEMS = 380;

    localparam int P_SKIP  = 0;
    localparam int P_START = 1;
    localparam int P_HDR   = 2;
    localparam int P_BODY  = 3;

    localparam logic [2:0] CLS_TARGET  = 3'd2;
    localparam logic [2:0] CLS_VERSION = 3'd3;

    typedef struct {
        logic [7:0] out_byte;
        logic [2:0] byte_class;
        logic       field_end;
        logic       message_end;
        logic [2:0] error_code;
        logic       last_of_run;
    } word_t;

    typedef struct {
        logic [7:0] b;
        bit         typed;
        logic [2:0] cls;
        logic       fe;
        logic       me;
    } row_t;

    logic clk;
    logic rst_n;
    hmf_in_if  raw_if();
    hmf_out_if framed_if();

    http_message_framer_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .raw    (raw_if),
        .framed (framed_if)
    );

    word_t      words_due[$];
    logic [7:0] stream_q[$];
    int         errors;
    int         bytes_sent;
    int         words_seen;
    int         messages_done;
    int         idle_pct;
    int         stall_pct;

    // framer state held by the predictor
    int          fr_phase;
    int          fr_tok;
    bit          fr_cr;
    bit          fr_empty;
    bit          fr_colon;
    bit          fr_vstart;
    int          fr_lprog;
    int          fr_eprog;
    bit          fr_has_len;
    bit          fr_has_enc;
    logic [63:0] fr_acc;
    logic [63:0] fr_body;
    bit          fr_held[HOLD];
    int          fr_held_cnt;
    logic [2:0]  fr_err;

    string len_str = "Content-Length";
    string enc_str = "Transfer-Encoding";

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void clear_line();
        fr_empty    = 1'b1;
        fr_colon    = 1'b0;
        fr_vstart   = 1'b0;
        fr_lprog    = 0;
        fr_eprog    = 0;
        fr_acc      = '0;
        fr_held_cnt = 0;
    endfunction

    function automatic void clear_message();
        clear_line();
        fr_phase   = P_SKIP;
        fr_tok     = 0;
        fr_cr      = 1'b0;
        fr_has_len = 1'b0;
        fr_has_enc = 1'b0;
        fr_body    = '0;
    endfunction

    function automatic void add_word(logic [7:0] b, logic [2:0] cls, logic fe, logic me);
        word_t w;
        w.out_byte    = b;
        w.byte_class  = cls;
        w.field_end   = fe;
        w.message_end = me;
        w.error_code  = fr_err;
        w.last_of_run = 1'b0;
        words_due.push_back(w);
    endfunction

    function automatic int name_step(int prog, string name, logic [7:0] b);
        if (prog < name.len() && name[prog] == b)
            return prog + 1;
        return int'(hmf_pkg::PROGRESS_DEAD);
    endfunction

    function automatic void close_line(ref logic fe, ref logic me);
        if (fr_phase == P_START)
        begin
            fe       = 1'b1;
            fr_phase = P_HDR;
            clear_line();
        end
        else if (fr_phase == P_HDR)
        begin
            if (fr_empty)
            begin
                if (fr_has_enc)
                    fr_err = hmf_pkg::ERR_TE;
                else if (!fr_has_len || fr_body == 0)
                begin
                    me = 1'b1;
                    clear_message();
                end
                else
                    fr_phase = P_BODY;
            end
            else if (!fr_colon || !fr_vstart)
                fr_err = hmf_pkg::ERR_HEADER;
            else
            begin
                fe = 1'b1;
                if (fr_eprog == hmf_pkg::ENC_NAME_SIZE)
                    fr_has_enc = 1'b1;
                if (fr_lprog == hmf_pkg::LEN_NAME_SIZE)
                begin
                    fr_has_len = 1'b1;
                    fr_body    = fr_acc;
                end
                clear_line();
            end
        end
    endfunction

    function automatic void value_char(logic [7:0] b);
        logic [63:0] d;
        logic [63:0] lim;
        if (b == hmf_pkg::CH_SP || b == hmf_pkg::CH_TAB)
        begin
            if (!fr_vstart)
                add_word(b, hmf_pkg::CLS_DROP, 1'b0, 1'b0);
            else if (fr_held_cnt < HOLD)
            begin
                fr_held[fr_held_cnt] = (b == hmf_pkg::CH_TAB);
                fr_held_cnt++;
            end
            else
            begin
                fr_err = hmf_pkg::ERR_HEADER;
                add_word(b, hmf_pkg::CLS_DROP, 1'b0, 1'b0);
            end
            return;
        end
        if (fr_lprog == hmf_pkg::LEN_NAME_SIZE)
        begin
            lim = (64'd1 << LEN_BITS) - 64'd1;
            d   = 64'(b) - 64'(hmf_pkg::CH_ZERO);
            if (b < hmf_pkg::CH_ZERO || b > hmf_pkg::CH_NINE || fr_held_cnt > 0
                || fr_acc > (lim - d) / 10)
            begin
                fr_err = hmf_pkg::ERR_LENGTH;
                add_word(b, hmf_pkg::CLS_DROP, 1'b0, 1'b0);
                return;
            end
            fr_acc = fr_acc * 10 + d;
        end
        fr_vstart = 1'b1;
        for (int i = 0; i < fr_held_cnt; i++)
            add_word(fr_held[i] ? hmf_pkg::CH_TAB : hmf_pkg::CH_SP, hmf_pkg::CLS_VALUE,
                     1'b0, 1'b0);
        fr_held_cnt = 0;
        add_word(b, hmf_pkg::CLS_VALUE, 1'b0, 1'b0);
    endfunction

    function automatic void frame_byte(logic [7:0] b);
        int   first;
        logic fe;
        logic me;
        first = words_due.size();
        fe    = 1'b0;
        me    = 1'b0;
        if (fr_phase > P_BODY)
            fr_phase = P_SKIP;
        if (fr_err != hmf_pkg::ERR_NONE)
            add_word(b, hmf_pkg::CLS_DROP, 1'b0, 1'b0);
        else if (fr_phase == P_BODY)
        begin
            if (fr_body > 0)
                fr_body--;
            if (fr_body == 0)
            begin
                me = 1'b1;
                clear_message();
            end
            add_word(b, hmf_pkg::CLS_BODY, 1'b0, me);
        end
        else if (fr_cr)
        begin
            fr_cr = 1'b0;
            if (b != hmf_pkg::CH_LF)
                fr_err = hmf_pkg::ERR_BARE_CR;
            else
                close_line(fe, me);
            add_word(b, hmf_pkg::CLS_DROP, fe, me);
        end
        else if (b == hmf_pkg::CH_CR)
        begin
            fr_cr = 1'b1;
            add_word(b, hmf_pkg::CLS_DROP, 1'b0, 1'b0);
        end
        else if (fr_phase == P_SKIP || fr_phase == P_START)
        begin
            fr_phase = P_START;
            if (b == hmf_pkg::CH_SP && fr_tok < 2)
            begin
                fr_tok++;
                add_word(b, hmf_pkg::CLS_DROP, 1'b1, 1'b0);
            end
            else
                add_word(b, hmf_pkg::CLS_METHOD + 3'(fr_tok), 1'b0, 1'b0);
        end
        else
        begin
            fr_empty = 1'b0;
            if (!fr_colon)
            begin
                if (b == hmf_pkg::CH_COLON)
                begin
                    fr_colon = 1'b1;
                    add_word(b, hmf_pkg::CLS_DROP, 1'b0, 1'b0);
                end
                else
                begin
                    fr_lprog = name_step(fr_lprog, len_str, b);
                    fr_eprog = name_step(fr_eprog, enc_str, b);
                    add_word(b, hmf_pkg::CLS_NAME, 1'b0, 1'b0);
                end
            end
            else
                value_char(b);
        end
        if (words_due.size() > first)
            words_due[words_due.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic send_byte(logic [7:0] b);
        while (($urandom_range(99)) < idle_pct)
        begin
            raw_if.valid <= 1'b0;
            @(posedge clk);
        end
        raw_if.valid     <= 1'b1;
        raw_if.data_byte <= b;
        do
            @(posedge clk);
        while (!raw_if.ready);
        bytes_sent++;
    endtask

    always @(posedge clk)
        framed_if.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && framed_if.valid && framed_if.ready)
        begin
            words_seen++;
            if (framed_if.message_end === 1'b1)
                messages_done++;
            if (words_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, actual byte=%h class=%0d", $realtime,
                         framed_if.out_byte, framed_if.byte_class);
            end
            else
            begin
                word_t w;
                w = words_due[0];
                words_due.delete(0);
                if (framed_if.out_byte !== w.out_byte || framed_if.byte_class !== w.byte_class
                    || framed_if.field_end !== w.field_end
                    || framed_if.message_end !== w.message_end
                    || framed_if.error_code !== w.error_code
                    || framed_if.last_of_run !== w.last_of_run)
                begin
                    errors++;
                    $display("%0t: mismatch expected b=%h c=%0d fe=%b me=%b e=%0d l=%b",
                             $realtime, w.out_byte, w.byte_class, w.field_end,
                             w.message_end, w.error_code, w.last_of_run);
                    $display("%0t:          actual b=%h c=%0d fe=%b me=%b e=%0d l=%b",
                             $realtime, framed_if.out_byte, framed_if.byte_class,
                             framed_if.field_end, framed_if.message_end,
                             framed_if.error_code, framed_if.last_of_run);
                end
            end
        end
    end

    function automatic logic [7:0] pick_byte(bit no_sp, bit no_colon);
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == hmf_pkg::CH_CR
               || (no_sp && (b == hmf_pkg::CH_SP || b == hmf_pkg::CH_TAB))
               || (no_colon && b == hmf_pkg::CH_COLON));
        return b;
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            stream_q.push_back(s[i]);
    endfunction

    function automatic void push_ws(int n);
        for (int i = 0; i < n; i++)
            stream_q.push_back($urandom_range(1) ? hmf_pkg::CH_TAB : hmf_pkg::CH_SP);
    endfunction

    function automatic void push_crlf();
        stream_q.push_back(hmf_pkg::CH_CR);
        stream_q.push_back(hmf_pkg::CH_LF);
    endfunction

    function automatic void build_message();
        int body_len;
        int n;
        body_len = 0;
        repeat ($urandom_range(2) == 0 ? $urandom_range(1, 2) : 0)
            push_crlf();
        for (int t = 0; t < 3; t++)
        begin
            repeat ($urandom_range(1, 4))
                stream_q.push_back(pick_byte(1'b1, 1'b0));
            if (t == 2 && $urandom_range(3) == 0)
                stream_q.push_back(hmf_pkg::CH_SP);
            if (t < 2)
                stream_q.push_back(hmf_pkg::CH_SP);
        end
        push_crlf();
        repeat ($urandom_range(0, 3))
        begin
            n = $urandom_range(9);
            if (n < 4)
            begin
                int v;
                v = $urandom_range(12);
                push_text(len_str);
                stream_q.push_back(hmf_pkg::CH_COLON);
                push_ws($urandom_range(2));
                if ($urandom_range(3) == 0)
                    stream_q.push_back(hmf_pkg::CH_ZERO);
                push_text($sformatf("%0d", v));
                push_ws($urandom_range(2));
                body_len = v;
            end
            else
            begin
                if (n == 4)
                begin
                    if ($urandom_range(1))
                        push_text("Content-Lengt");
                    else
                        push_text("content-length");
                end
                else if (n == 5)
                    push_text("Transfer-Encodin");
                else
                    repeat ($urandom_range(1, 6))
                        stream_q.push_back(pick_byte(1'b0, 1'b1));
                stream_q.push_back(hmf_pkg::CH_COLON);
                push_ws($urandom_range(2));
                repeat ($urandom_range(1, 4))
                begin
                    repeat ($urandom_range(1, 3))
                        stream_q.push_back(pick_byte(1'b1, 1'b0));
                    push_ws($urandom_range(5) == 0 ? HOLD : $urandom_range(3));
                end
            end
            push_crlf();
        end
        push_crlf();
        repeat (body_len)
            stream_q.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void build_error_tail();
        push_text("G / H");
        push_crlf();
        case ($urandom_range(4))
            0: push_text("A:x\rz");
            1: begin
                push_text("noval:");
                push_ws(2);
                push_crlf();
            end
            2: begin
                push_text("Transfer-Encoding: chunked");
                push_crlf();
                push_crlf();
            end
            3: begin
                push_text("Content-Length: 99999999999");
                push_crlf();
            end
            default: begin
                push_text("X: a");
                push_ws(HOLD + 1);
                push_text("b");
            end
        endcase
        repeat (12)
            stream_q.push_back(8'($urandom_range(255)));
    endfunction

    function automatic row_t mk(logic [7:0] b);
        row_t r;
        r.b     = b;
        r.typed = 1'b0;
        r.cls   = hmf_pkg::CLS_DROP;
        r.fe    = 1'b0;
        r.me    = 1'b0;
        return r;
    endfunction

    function automatic row_t mk_typed(logic [7:0] b, logic [2:0] cls, logic fe, logic me);
        row_t r;
        r       = mk(b);
        r.typed = 1'b1;
        r.cls   = cls;
        r.fe    = fe;
        r.me    = me;
        return r;
    endfunction

    initial
    begin
        row_t rows[$];
        errors           = 0;
        bytes_sent       = 0;
        words_seen       = 0;
        messages_done    = 0;
        idle_pct         = 0;
        stall_pct        = 0;
        fr_err           = hmf_pkg::ERR_NONE;
        clear_message();
        rst_n            = 1'b0;
        raw_if.valid     = 1'b0;
        raw_if.data_byte = 8'h00;
        framed_if.ready  = 1'b0;

        rows = '{mk_typed(hmf_pkg::CH_CR, hmf_pkg::CLS_DROP, 1'b0, 1'b0), mk(hmf_pkg::CH_LF),
                 mk_typed("M", hmf_pkg::CLS_METHOD, 1'b0, 1'b0),
                 mk_typed(hmf_pkg::CH_SP, hmf_pkg::CLS_DROP, 1'b1, 1'b0),
                 mk_typed(8'hFF, CLS_TARGET, 1'b0, 1'b0), mk(hmf_pkg::CH_SP),
                 mk_typed(8'h00, CLS_VERSION, 1'b0, 1'b0), mk(hmf_pkg::CH_SP),
                 mk(hmf_pkg::CH_LF),
                 mk(hmf_pkg::CH_CR), mk(hmf_pkg::CH_LF),
                 mk_typed("A", hmf_pkg::CLS_NAME, 1'b0, 1'b0), mk(hmf_pkg::CH_COLON),
                 mk_typed(hmf_pkg::CH_TAB, hmf_pkg::CLS_DROP, 1'b0, 1'b0),
                 mk(hmf_pkg::CH_SP), mk("x"),
                 mk(hmf_pkg::CH_SP), mk(hmf_pkg::CH_TAB), mk("y"), mk(hmf_pkg::CH_SP),
                 mk(hmf_pkg::CH_CR), mk(hmf_pkg::CH_LF),
                 mk(hmf_pkg::CH_CR), mk_typed(hmf_pkg::CH_LF, hmf_pkg::CLS_DROP, 1'b0, 1'b1)};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_byte(rows[i].b);
            if (rows[i].typed)
            begin
                int first;
                first = words_due.size();
                frame_byte(rows[i].b);
                while (words_due.size() > first)
                    void'(words_due.pop_back());
                add_word(rows[i].b, rows[i].cls, rows[i].fe, rows[i].me);
                words_due[words_due.size() - 1].last_of_run = 1'b1;
            end
            else
                frame_byte(rows[i].b);
        end

        while (bytes_sent + stream_q.size() < RAND_ITEMS)
            build_message();
        build_error_tail();
        while (stream_q.size() > 0)
        begin
            int k;
            logic [7:0] b;
            k = (bytes_sent * 4) / (RAND_ITEMS + 80);
            idle_pct  = (k == 1 || k == 3) ? ((k == 3) ? 24 : 52) : 0;
            stall_pct = (k == 2 || k >= 3) ? ((k >= 3) ? 24 : 52) : 0;
            b = stream_q[0];
            stream_q.delete(0);
            send_byte(b);
            frame_byte(b);
        end
        raw_if.valid <= 1'b0;

        begin
            int waited;
            waited = 0;
            while (words_due.size() > 0 && waited < 20000)
            begin
                @(posedge clk);
                waited++;
            end
        end
        repeat (40) @(posedge clk);
        if (words_due.size() > 0)
        begin
            errors++;
            $display("%0t: %0d expected words never arrived", $realtime, words_due.size());
        end
        $display("Sent %0d bytes, checked %0d words, %0d complete messages, final error %0d",
                 bytes_sent, words_seen, messages_done, fr_err);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
